/* sv/ipd_pkg.sv */
package ipd_pkg;

   localparam int HDR_LEN = 7;
   localparam int POS_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       link_up;
   } req_type;

   typedef struct packed {
      logic        chunk_valid;
      logic [63:0] chunk_bytes;
      logic [3:0]  chunk_count;
      logic [31:0] short_payload_errors;
      logic [31:0] length_errors;
   } rsp_type;

   // One classified word as handed from the front end to the back end.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       link_up;
      logic       hdr_done;
      logic       is_digit;
      logic       is_colon;
      logic [3:0] digit;
   } item_type;

   // Characters of the "+IPD,0," header by position.
   function automatic logic [7:0] hdr_char(input logic [POS_W-1:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0: c = 8'h2B;
         3'd1: c = 8'h49;
         3'd2: c = 8'h50;
         3'd3: c = 8'h44;
         3'd4: c = 8'h2C;
         3'd5: c = 8'h30;
         3'd6: c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* sv/ipd_front.sv */
module ipd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  ipd_pkg::req_type  req_payload,
   input  logic              q_full,
   output logic              req_stall,
   output logic              push,
   output ipd_pkg::item_type push_item
);
   import ipd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] pos_step;
   logic             match_done;
   logic [7:0]       b;
   logic [7:0]       digit_diff;

   assign b = req_payload.rx_byte;
   assign req_stall = q_full;
   assign push = req_valid && !q_full;
   assign digit_diff = b - CHAR_ZERO;

   always_comb begin
      // On a mismatch the matcher restarts, trying the byte as the first character.
      if (b == hdr_char(pos_ff)) begin
         pos_step = pos_ff + POS_W'(1);
      end else if (b == CHAR_PLUS) begin
         pos_step = POS_W'(1);
      end else begin
         pos_step = '0;
      end
      match_done = (pos_step == POS_W'(HDR_LEN));
      pos_in = pos_ff;
      if (push) begin
         pos_in = match_done ? '0 : pos_step;
      end
   end

   always_comb begin
      push_item.rx_byte  = b;
      push_item.link_up  = req_payload.link_up;
      push_item.hdr_done = match_done;
      push_item.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      push_item.is_colon = (b == CHAR_COLON);
      push_item.digit    = digit_diff[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* sv/ipd_queue.sv */
module ipd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipd_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              q_valid,
   output ipd_pkg::item_type q_item
);
   import ipd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/ipd_back.sv */
module ipd_back #(
   parameter int MAX_PAYLOAD = 256,
   parameter int CHUNK_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  ipd_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ipd_pkg::rsp_type  rsp_payload
);
   import ipd_pkg::*;

   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ACC_W  = LEN_W + 4;
   localparam int SLOT_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int CNT_W  = 16;
   localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
   localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PAYLOAD);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHUNK_BYTES - 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       short_err_ff, short_err_in;
   logic [31:0]       len_err_ff, len_err_in;
   logic [7:0]        store_ff [CHUNK_BYTES];
   logic [7:0]        store_in [CHUNK_BYTES];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic              load;
   logic [ACC_W-1:0]  acc;
   logic              emit;
   logic [3:0]        emit_n;
   logic [63:0]       store_flat;
   logic [63:0]       packed_bytes;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_valid && load;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Length digit accumulation: times ten as two shifts and an add.
   assign acc = (ACC_W'(len_ff) << 3) + (ACC_W'(len_ff) << 1) + ACC_W'(q_item.digit);

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      short_err_in = short_err_ff;
      len_err_in   = len_err_ff;
      emit         = 1'b0;
      emit_n       = '0;
      for (int i = 0; i < CHUNK_BYTES; i++) begin
         store_in[i] = store_ff[i];
      end

      if (q_item.hdr_done) begin
         if (cnt_ff != CNT_W'(len_ff)) begin
            short_err_in = short_err_ff + 32'd1;
         end
         if (q_item.link_up) begin
            len_in   = '0;
            cnt_in   = '0;
            slot_in  = '0;
            phase_in = PH_LEN;
         end else begin
            phase_in = PH_IDLE;
         end
      end else if (phase_ff == PH_LEN) begin
         if (!q_item.is_colon) begin
            if (q_item.is_digit) begin
               len_in = (acc > ACC_W'(MAX_PAYLOAD)) ? MAX_LEN : acc[LEN_W-1:0];
            end else begin
               len_err_in = len_err_ff + 32'd1;
               phase_in   = PH_IDLE;
            end
         end else if (len_ff < MAX_LEN) begin
            phase_in = PH_DATA;
         end else begin
            len_err_in = len_err_ff + 32'd1;
            phase_in   = PH_IDLE;
         end
      end else if (phase_ff == PH_DATA) begin
         for (int i = 0; i < CHUNK_BYTES; i++) begin
            if (slot_ff == SLOT_W'(i)) begin
               store_in[i] = q_item.rx_byte;
            end
         end
         // Once the count saturates, the same slot is overwritten and nothing is emitted.
         if (cnt_ff != COUNT_MAX) begin
            cnt_in  = cnt_ff + CNT_W'(1);
            slot_in = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
            if (cnt_in == CNT_W'(len_ff)) begin
               emit     = 1'b1;
               emit_n   = 4'(slot_ff) + 4'd1;
               phase_in = PH_IDLE;
            end else if (slot_ff == LAST_SLOT) begin
               emit   = 1'b1;
               emit_n = 4'(CHUNK_BYTES);
            end
         end
      end
   end

   always_comb begin
      store_flat = '0;
      for (int i = 0; i < CHUNK_BYTES; i++) begin
         store_flat[8*i +: 8] = store_in[i];
      end
      packed_bytes = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < emit_n) begin
            packed_bytes[8*i +: 8] = store_flat[8*i +: 8];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in = q_valid;
      end
      if (q_pop) begin
         rsp_payload_in.chunk_valid          = emit;
         rsp_payload_in.chunk_bytes          = packed_bytes;
         rsp_payload_in.chunk_count          = emit_n;
         rsp_payload_in.short_payload_errors = short_err_in;
         rsp_payload_in.length_errors        = len_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < CHUNK_BYTES; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         slot_ff      <= '0;
         short_err_ff <= '0;
         len_err_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff     <= phase_in;
            len_ff       <= len_in;
            cnt_ff       <= cnt_in;
            slot_ff      <= slot_in;
            short_err_ff <= short_err_in;
            len_err_ff   <= len_err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/ipd_frame_deframer_top.sv */
// A word accepted on req is held in a queue entry and then in the output register before its result shows on rsp.
// Throughput: one word per cycle while req_stall is low, set by the parser update in the back end.
// A two-entry queue between the header matcher and the parser buffers words while rsp stalls.
// Reset (synchronous, active high) empties the queue and output register, returns the
// parser to idle and clears the header position, length, byte count and both error counters.
module ipd_frame_deframer_top #(
   parameter int MAX_PAYLOAD = 256,
   parameter int CHUNK_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ipd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ipd_pkg::rsp_type rsp_payload
);
   import ipd_pkg::*;

   logic     push;
   item_type push_item;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   item_type q_item;

   ipd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_item   (push_item)
   );

   ipd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   ipd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
